>>> design/lld_pkg.sv
// ----------------------------------------------------------------------------
// Linked list deque package
// Shared constants and codes for the deque with key delete.
// ----------------------------------------------------------------------------
package lld_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned KeyW        = 32;

  // Request codes.
  localparam logic [2:0] REQ_INSERT  = 3'd0;
  localparam logic [2:0] REQ_DEL_KEY = 3'd1;
  localparam logic [2:0] REQ_DEL_FST = 3'd2;
  localparam logic [2:0] REQ_DEL_LST = 3'd3;
  localparam logic [2:0] REQ_DUMP    = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_DONE  = 3'd0;
  localparam logic [2:0] ST_NOKEY = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_DUMP  = 3'd4;

endpackage

>>> design/lld_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module lld_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/linked_list_deque_with_key_delete_unit.sv
// ----------------------------------------------------------------------------
// Linked list deque with key delete
// Bounded doubly linked list of keys with links in RAM.
// ----------------------------------------------------------------------------
// Insert writes the new entry (S_FIND), then patches the old head (S_UNL2). Delete
// first/last reads the end entry (S_RD, S_CHK) and unlinks it (S_UNL, S_UNL2); delete by
// key reads and compares each entry from the head on until a match or the list ends. Full,
// empty and unused-code replies come straight from idle. A dump sends one beat per entry.
// One request at a time: input is ready again once the final beat is taken and it is idle.
// Reset clears the used map, head, tail and count; the RAMs hold no reset.
module linked_list_deque_with_key_delete_unit
  import lld_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [39:0] s_tdata_i,   // [2:0] req_type, [34:3] key
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,   // [2:0] status, [34:3] out_key
  output logic        m_tlast_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_FIND = 8'b0000_0010,
    S_RD   = 8'b0000_0100,
    S_CHK  = 8'b0000_1000,
    S_UNL  = 8'b0001_0000,
    S_UNL2 = 8'b0010_0000,
    S_OUT  = 8'b0100_0000,
    S_DRD  = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [CAPACITY-1:0] used_q, used_d;
  logic [IdxW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [2:0]        req_q, req_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [IdxW-1:0]   cur_q, cur_d;
  logic [CntW-1:0]   iter_q, iter_d;
  logic [IdxW-1:0]   free_q, free_d;
  logic              obusy_q, obusy_d;
  logic [2:0]        ost_q, ost_d;
  logic [KeyW-1:0]   okey_q, okey_d;
  logic              olast_q, olast_d;

  // RAM ports.
  logic            k_we, n_we, p_we;
  logic [IdxW-1:0] k_wa, n_wa, p_wa, rd_a;
  logic [KeyW-1:0] k_wd, k_rd;
  logic [IdxW-1:0] n_wd, n_rd, p_wd, p_rd;

  lld_ram #(.Width(KeyW), .Depth(2**IdxW)) u_key (
    .clk_i, .we_i(k_we), .waddr_i(k_wa), .wdata_i(k_wd), .raddr_i(rd_a), .rdata_o(k_rd));
  lld_ram #(.Width(IdxW), .Depth(2**IdxW)) u_next (
    .clk_i, .we_i(n_we), .waddr_i(n_wa), .wdata_i(n_wd), .raddr_i(rd_a), .rdata_o(n_rd));
  lld_ram #(.Width(IdxW), .Depth(2**IdxW)) u_prev (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(rd_a), .rdata_o(p_rd));

  // Lowest free slot, searched over the used map.
  logic [IdxW-1:0] free_idx;
  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used_q[i]) free_idx = IdxW'(i);
    end
  end

  assign s_tready_o = (state_q == S_IDLE) && !obusy_q;
  assign m_tvalid_o = obusy_q;
  assign m_tdata_o  = {5'd0, okey_q, ost_q};
  assign m_tlast_o  = olast_q;

  logic s_acc;
  assign s_acc = s_tvalid_i && s_tready_o;

  // Control sequencer.
  always_comb begin
    state_d = state_q; used_d = used_q; head_d = head_q; tail_d = tail_q;
    cnt_d = cnt_q; req_d = req_q; key_d = key_q; cur_d = cur_q; iter_d = iter_q;
    free_d = free_q; obusy_d = obusy_q; ost_d = ost_q; okey_d = okey_q;
    olast_d = olast_q;
    k_we = 1'b0; n_we = 1'b0; p_we = 1'b0;
    k_wa = free_q; n_wa = free_q; p_wa = free_q;
    k_wd = key_q; n_wd = head_q; p_wd = free_q;
    rd_a = cur_q;
    if (obusy_q && m_tready_i) obusy_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          req_d = s_tdata_i[2:0];
          key_d = s_tdata_i[34:3];
          free_d = free_idx;
          iter_d = '0;
          ost_d = ST_DONE; okey_d = '0; olast_d = 1'b1;
          case (s_tdata_i[2:0])
            REQ_INSERT: begin
              if (cnt_q == CntW'(CAPACITY)) begin
                ost_d = ST_FULL; obusy_d = 1'b1;
              end else begin
                state_d = S_FIND;
              end
            end
            REQ_DEL_KEY, REQ_DEL_FST, REQ_DUMP: begin
              if (cnt_q == '0) begin
                ost_d = ST_EMPTY; obusy_d = 1'b1;
              end else begin
                cur_d = head_q; state_d = S_RD;
              end
            end
            REQ_DEL_LST: begin
              if (cnt_q == '0) begin
                ost_d = ST_EMPTY; obusy_d = 1'b1;
              end else begin
                cur_d = tail_q; state_d = S_RD;
              end
            end
            default: obusy_d = 1'b1;
          endcase
        end
      end
      // Insert: write the new entry and patch the old head.
      S_FIND: begin
        k_we = 1'b1; n_we = 1'b1; p_we = 1'b1;
        n_wd = (cnt_q == '0) ? free_q : head_q;
        used_d[free_q] = 1'b1;
        if (cnt_q == '0) tail_d = free_q;
        state_d = S_UNL2;
      end
      S_UNL2: begin
        if (req_q == REQ_INSERT) begin
          if (cnt_q != '0) begin
            p_we = 1'b1; p_wa = head_q; p_wd = free_q;
          end
          head_d = free_q; cnt_d = cnt_q + 1'b1;
          obusy_d = 1'b1; state_d = S_OUT;
        end else begin
          // Second half of unlink: prev link of the successor.
          if (cur_q != tail_q) begin
            p_we = 1'b1; p_wa = n_rd; p_wd = p_rd;
          end else begin
            tail_d = p_rd;
          end
          if (cur_q == head_q) head_d = n_rd;
          used_d[cur_q] = 1'b0;
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) begin
            head_d = '0; tail_d = '0;
          end
          obusy_d = 1'b1; state_d = S_OUT;
        end
      end
      // Read latency cycle.
      S_RD: state_d = S_CHK;
      S_CHK: begin
        if (req_q == REQ_DUMP) begin
          if (!obusy_q) begin
            ost_d = ST_DUMP; okey_d = k_rd;
            olast_d = (iter_q == cnt_q - 1'b1);
            obusy_d = 1'b1;
            iter_d = iter_q + 1'b1;
            cur_d = n_rd;
            state_d = (iter_q == cnt_q - 1'b1) ? S_OUT : S_DRD;
          end
        end else if (req_q != REQ_DEL_KEY || k_rd == key_q) begin
          state_d = S_UNL;
        end else if (iter_q == cnt_q - 1'b1) begin
          ost_d = ST_NOKEY; obusy_d = 1'b1; state_d = S_OUT;
        end else begin
          iter_d = iter_q + 1'b1; cur_d = n_rd; state_d = S_RD;
        end
      end
      S_DRD: begin
        rd_a = cur_q; state_d = S_CHK;
      end
      // First half of unlink: next link of the predecessor.
      S_UNL: begin
        if (cur_q != head_q) begin
          n_we = 1'b1; n_wa = p_rd; n_wd = n_rd;
        end
        state_d = S_UNL2;
      end
      S_OUT: begin
        if (!obusy_q) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // RAM read address stays on cur so held read data stays valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; used_q <= '0; head_q <= '0; tail_q <= '0;
      cnt_q <= '0; obusy_q <= 1'b0;
    end else begin
      state_q <= state_d; used_q <= used_d; head_q <= head_d; tail_q <= tail_d;
      cnt_q <= cnt_d; obusy_q <= obusy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; key_q <= key_d; cur_q <= cur_d; iter_q <= iter_d;
    free_q <= free_d; ost_q <= ost_d; okey_q <= okey_d; olast_q <= olast_d;
  end

  // Checks.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY)) else $error("count over capacity");
  a_cnt_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(used_q) == int'(cnt_q)))
    else $error("used map and count disagree");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_tready_o) else $error("accept while busy");

endmodule
